/* design/i2c_master_transfer_sequencer_top_assert.svh */
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/i2cms_pkg.sv */
package i2cms_pkg;

	localparam int unsigned TX_DEPTH_DEF = 256;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	typedef enum logic [2:0] {
		KIND_BEGIN   = 3'd0,
		KIND_LOAD    = 3'd1,
		KIND_BUS     = 3'd2,
		KIND_ERROR   = 3'd3,
		KIND_TIMEOUT = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		REG_TARGET_ADDRESS = 2'd0,
		REG_WRITE_LENGTH   = 2'd1,
		REG_READ_LENGTH    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_BEGIN,
		OP_LOAD,
		OP_BUS,
		OP_ERROR,
		OP_TIMEOUT,
		OP_IGNORE
	} op_t;

	typedef enum logic [1:0] {
		CTL_KEEP    = 2'd0,
		CTL_ENABLE  = 2'd1,
		CTL_DISABLE = 2'd2
	} ctl_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_DEVICE  = 3'd1,
		ST_BUS_ERROR  = 3'd2,
		ST_TIMEOUT    = 3'd3,
		ST_UNEXPECTED = 3'd4
	} status_t;

	// classified beat, front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] load_index;
		logic [7:0] byte_val;
		logic       start_sent;
		logic       address_done;
		logic       rx_not_empty;
		logic       tx_empty;
		logic       byte_finished;
		logic       err_stop;
		status_t    err_status;
	} item_t;

	// one command record
	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        gen_start;
		logic        gen_stop;
		ctl_t        ack_control;
		ctl_t        buffer_irq_control;
		logic        dummy_read;
		logic        rx_valid;
		logic [15:0] rx_index;
		logic [7:0]  rx_byte;
		logic        done_res;
		status_t     status;
	} out_rec_t;

endpackage

/* design/i2cms_ram.sv */
module i2cms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* design/i2cms_front.sv */
module i2cms_front
	import i2cms_pkg::*;
(
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [7:0] load_index,
	input  logic [7:0] byte_in,
	input  logic       start_sent,
	input  logic       address_done,
	input  logic       rx_not_empty,
	input  logic       tx_empty,
	input  logic       byte_finished,
	input  logic       ack_failure,
	input  logic       bus_fault,
	input  logic       queue_full,
	output logic       push,
	output item_t      push_item
);

	always_comb begin
		push_item               = '0;
		push_item.load_index    = load_index;
		push_item.byte_val      = byte_in;
		push_item.start_sent    = start_sent;
		push_item.address_done  = address_done;
		push_item.rx_not_empty  = rx_not_empty;
		push_item.tx_empty      = tx_empty;
		push_item.byte_finished = byte_finished;
		case (kind_t'(kind))
			KIND_BEGIN:   push_item.op = OP_BEGIN;
			KIND_LOAD:    push_item.op = OP_LOAD;
			KIND_BUS:     push_item.op = OP_BUS;
			KIND_ERROR:   push_item.op = OP_ERROR;
			KIND_TIMEOUT: push_item.op = OP_TIMEOUT;
			default:      push_item.op = OP_IGNORE;
		endcase
		// NACK wins over bus fault
		if (ack_failure) begin
			push_item.err_stop   = 1'b1;
			push_item.err_status = ST_NO_DEVICE;
		end else if (bus_fault) begin
			push_item.err_status = ST_BUS_ERROR;
		end else begin
			push_item.err_status = ST_UNEXPECTED;
		end
	end

	assign in_stall = queue_full;
	assign push     = in_valid;

endmodule

/* design/i2cms_queue.sv */
module i2cms_queue
	import i2cms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  head_valid,
	output item_t head_item,
	input  logic  pop
);

	localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t          slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == (QAW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/i2cms_back.sv */
module i2cms_back
	import i2cms_pkg::*;
#(
	parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   head_valid,
	input  item_t                  head_item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_rec_t               out_rec
);

	localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

	logic [6:0]  target_address_q;
	logic [8:0]  write_length_q;
	logic [15:0] read_length_q;

	logic        busy_q, busy_d;
	logic        wr_exh_q, wr_exh_d;
	logic        wr_over_q, wr_over_d;
	logic [15:0] pos_q, pos_d;
	logic [AW-1:0] tp_q, tp_d;

	logic          fwd_q;
	logic [7:0]    fwd_byte_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_rdata;
	logic [7:0]    tx_byte;

	logic [AW-1:0] idx_mod [256];

	logic          out_valid_q;
	out_rec_t      out_rec_q;
	out_rec_t      rec;

	logic [16:0]   rx_diff;
	logic [16:0]   tx_diff;
	logic          rx_gt0, rx_gt1, rx_gt2;
	logic          tx_zero, tx_le1;
	logic [15:0]   pos_inc;
	logic [AW-1:0] tp_inc;
	logic          finish;
	status_t       fin_status;

	function automatic logic rx_le_tx_zero(input logic [16:0] d);
		return d[16] || (d[15:0] == 16'd0);
	endfunction

	// load index modulo depth, fixed at elaboration
	for (genvar gi = 0; gi < 256; gi++) begin : g_idx_mod
		localparam int unsigned MODV = gi % TX_DEPTH;
		assign idx_mod[gi] = AW'(MODV);
	end

	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign ram_waddr = idx_mod[head_item.load_index];
	assign tx_byte   = fwd_q ? fwd_byte_q : ram_rdata;

	// remaining counts against the shared position
	assign rx_diff = {1'b0, read_length_q} - {1'b0, pos_q};
	assign tx_diff = {8'b0, write_length_q} - {1'b0, pos_q};
	assign rx_gt0  = !rx_diff[16] && (rx_diff[15:0] != 16'd0);
	assign rx_gt1  = !rx_diff[16] && (rx_diff[15:0] > 16'd1);
	assign rx_gt2  = !rx_diff[16] && (rx_diff[15:0] > 16'd2);
	assign tx_zero = wr_exh_q || rx_le_tx_zero(tx_diff);
	assign tx_le1  = wr_exh_q || tx_diff[16] || (tx_diff[15:0] <= 16'd1);

	// position and its buffer index move together; a 16-bit wrap lands on 0
	assign pos_inc = pos_q + 16'd1;
	assign tp_inc  = ((tp_q == AW'(TX_DEPTH - 1)) || (pos_q == 16'hFFFF)) ? '0 : tp_q + 1'b1;

	always_comb begin
		rec        = '0;
		busy_d     = busy_q;
		wr_exh_d   = wr_exh_q;
		wr_over_d  = wr_over_q;
		pos_d      = pos_q;
		tp_d       = tp_q;
		ram_we     = 1'b0;
		finish     = 1'b0;
		fin_status = ST_OK;
		if (pop) begin
			case (head_item.op)
				OP_BEGIN: begin
					if (!busy_q) begin
						busy_d        = 1'b1;
						pos_d         = '0;
						tp_d          = '0;
						wr_exh_d      = (write_length_q == 9'd0);
						wr_over_d     = (write_length_q == 9'd0);
						rec.gen_start = 1'b1;
					end
				end
				OP_LOAD: begin
					ram_we = 1'b1;
				end
				OP_BUS: begin
					if (busy_q) begin
						if (head_item.start_sent) begin
							rec.send_valid = 1'b1;
							rec.send_byte  = {target_address_q, tx_zero};
						end else begin
							if (head_item.address_done && tx_zero) begin
								rec.ack_control        = rx_gt1 ? CTL_ENABLE : CTL_DISABLE;
								rec.buffer_irq_control = CTL_ENABLE;
							end
							if (head_item.rx_not_empty && rx_gt0) begin
								rec.rx_valid = 1'b1;
								rec.rx_index = pos_q;
								rec.rx_byte  = head_item.byte_val;
								pos_d        = pos_inc;
								tp_d         = tp_inc;
								if (!rx_gt1) begin
									rec.gen_stop = 1'b1;
									finish       = 1'b1;
								end else begin
									rec.ack_control = rx_gt2 ? CTL_ENABLE : CTL_DISABLE;
								end
							end else if (head_item.tx_empty && !wr_over_q) begin
								if (wr_exh_q) begin
									pos_d          = '0;
									tp_d           = '0;
									rec.dummy_read = head_item.byte_finished;
									if (read_length_q != 16'd0) begin
										rec.gen_start = 1'b1;
									end else begin
										rec.gen_stop = 1'b1;
										finish       = 1'b1;
									end
									wr_over_d = 1'b1;
								end else begin
									rec.buffer_irq_control = tx_le1 ? CTL_DISABLE : CTL_ENABLE;
									rec.send_valid         = 1'b1;
									rec.send_byte          = tx_byte;
									pos_d                  = pos_inc;
									tp_d                   = tp_inc;
									if ({7'b0, write_length_q} <= pos_inc) begin
										wr_exh_d = 1'b1;
									end
								end
							end
						end
					end
				end
				OP_ERROR: begin
					if (busy_q) begin
						rec.gen_stop = head_item.err_stop;
						finish       = 1'b1;
						fin_status   = head_item.err_status;
					end
				end
				OP_TIMEOUT: begin
					if (busy_q) begin
						finish     = 1'b1;
						fin_status = ST_TIMEOUT;
					end
				end
				default: begin
				end
			endcase
			if (finish) begin
				rec.done_res           = 1'b1;
				rec.status             = fin_status;
				rec.buffer_irq_control = CTL_DISABLE;
				busy_d                 = 1'b0;
			end
		end
	end

	// read address follows the next position, so data is ready for the next beat
	i2cms_ram #(
		.WIDTH (8),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (head_item.byte_val),
		.rd_addr (tp_d),
		.rd_data (ram_rdata)
	);

	// catch a write landing on the word read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= ram_we && (ram_waddr == tp_d);
		end
	end

	always_ff @(posedge clk) begin
		fwd_byte_q <= head_item.byte_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= '0;
			write_length_q   <= '0;
			read_length_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TARGET_ADDRESS: target_address_q <= cfg_data[6:0];
				REG_WRITE_LENGTH:   write_length_q   <= cfg_data[8:0];
				REG_READ_LENGTH:    read_length_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			wr_exh_q  <= 1'b1;
			wr_over_q <= 1'b1;
			pos_q     <= '0;
			tp_q      <= '0;
		end else begin
			busy_q    <= busy_d;
			wr_exh_q  <= wr_exh_d;
			wr_over_q <= wr_over_d;
			pos_q     <= pos_d;
			tp_q      <= tp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_rec_q <= rec;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;

endmodule

/* design/i2c_master_transfer_sequencer_top.sv */
// Path: an accepted beat passes the queue and the execute stage; its command
// record is held in the output register until taken. Throughput: one beat per
// cycle while the output register is free, set by the single execute stage and
// its one tx buffer read port; a two-entry queue decouples input from output.
// Reset (arst_n low, asynchronous): idle, position 0, phase flags set, registers 0,
// queue and output empty. The tx buffer keeps its contents and is never cleared.
module i2c_master_transfer_sequencer_top
	import i2cms_pkg::*;
#(
	parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration, write only
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             kind,
	input  logic [7:0]             load_index,
	input  logic [7:0]             byte_in,
	input  logic                   start_sent,
	input  logic                   address_done,
	input  logic                   rx_not_empty,
	input  logic                   tx_empty,
	input  logic                   byte_finished,
	input  logic                   ack_failure,
	input  logic                   bus_fault,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   send_valid,
	output logic [7:0]             send_byte,
	output logic                   gen_start,
	output logic                   gen_stop,
	output logic [1:0]             ack_control,
	output logic [1:0]             buffer_irq_control,
	output logic                   dummy_read,
	output logic                   rx_valid,
	output logic [15:0]            rx_index,
	output logic [7:0]             rx_byte,
	output logic                   done_res,
	output logic [2:0]             status
);

	// front to queue
	logic     push;
	item_t    push_item;
	logic     queue_full;

	// queue to back
	logic     head_valid;
	item_t    head_item;
	logic     pop;

	out_rec_t out_rec;

	// Front: decodes kind into an operation and folds the error flags into a
	// status code. Stalls only when the queue is full.
	i2cms_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.load_index    (load_index),
		.byte_in       (byte_in),
		.start_sent    (start_sent),
		.address_done  (address_done),
		.rx_not_empty  (rx_not_empty),
		.tx_empty      (tx_empty),
		.byte_finished (byte_finished),
		.ack_failure   (ack_failure),
		.bus_fault     (bus_fault),
		.queue_full    (queue_full),
		.push          (push),
		.push_item     (push_item)
	);

	// Short queue: a full output register does not stall the input at once.
	i2cms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	// Back: transaction state, tx buffer and the registered command record.
	// One beat is executed per cycle whenever the output register is free.
	i2cms_back #(
		.TX_DEPTH (TX_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_rec    (out_rec)
	);

	// unpack the record onto the output fields
	assign send_valid         = out_rec.send_valid;
	assign send_byte          = out_rec.send_byte;
	assign gen_start          = out_rec.gen_start;
	assign gen_stop           = out_rec.gen_stop;
	assign ack_control        = out_rec.ack_control;
	assign buffer_irq_control = out_rec.buffer_irq_control;
	assign dummy_read         = out_rec.dummy_read;
	assign rx_valid           = out_rec.rx_valid;
	assign rx_index           = out_rec.rx_index;
	assign rx_byte            = out_rec.rx_byte;
	assign done_res           = out_rec.done_res;
	assign status             = out_rec.status;

endmodule

/* design/i2cms_checker.sv */
`include "i2c_master_transfer_sequencer_top_assert.svh"

module i2cms_checker
	import i2cms_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        send_valid,
	input logic [7:0]  send_byte,
	input logic        gen_start,
	input logic        gen_stop,
	input logic [1:0]  buffer_irq_control,
	input logic        rx_valid,
	input logic [15:0] rx_index,
	input logic        done_res,
	input logic [2:0]  status
);

	`I2CMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(send_byte) && $stable(rx_index) && $stable(status), "stalled output beat changed")
	`I2CMS_ASSERT_NOW(a_done_irq_off, out_valid && done_res, buffer_irq_control == CTL_DISABLE, "completion without buffer interrupt disable")
	`I2CMS_ASSERT_NOW(a_status_done, out_valid && (status != ST_OK), done_res, "error status without completion")
	`I2CMS_ASSERT_NOW(a_rx_no_send, out_valid && rx_valid, !send_valid && !gen_start, "received byte alongside a send or start")
	`I2CMS_ASSERT_NOW(a_start_stop, out_valid && gen_start, !gen_stop && !done_res, "start and stop in one record")

endmodule

bind i2c_master_transfer_sequencer_top i2cms_checker u_checker (.*);

/* test/i2c_master_transfer_sequencer_top_test.sv */
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_top_test
	import i2cms_pkg::*;
();

	// cycles with no beat on either side before the run is abandoned
	localparam int IDLE_LIMIT = 2000;

	// one input beat, field for field as on the ports
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] load_index;
		logic [7:0] byte_in;
		logic       start_sent;
		logic       address_done;
		logic       rx_not_empty;
		logic       tx_empty;
		logic       byte_finished;
		logic       ack_failure;
		logic       bus_fault;
	} beat_t;

	// every block input has a known value from time zero
	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   in_valid      = 1'b0;
	logic                   in_stall;
	logic [2:0]             kind          = '0;
	logic [7:0]             load_index    = '0;
	logic [7:0]             byte_in       = '0;
	logic                   start_sent    = 1'b0;
	logic                   address_done  = 1'b0;
	logic                   rx_not_empty  = 1'b0;
	logic                   tx_empty      = 1'b0;
	logic                   byte_finished = 1'b0;
	logic                   ack_failure   = 1'b0;
	logic                   bus_fault     = 1'b0;
	logic                   out_valid;
	logic                   out_stall     = 1'b0;
	logic                   send_valid;
	logic [7:0]             send_byte;
	logic                   gen_start;
	logic                   gen_stop;
	logic [1:0]             ack_control;
	logic [1:0]             buffer_irq_control;
	logic                   dummy_read;
	logic                   rx_valid;
	logic [15:0]            rx_index;
	logic [7:0]             rx_byte;
	logic                   done_res;
	logic [2:0]             status;

	i2c_master_transfer_sequencer_top dut (.*);

	always #5 clk = ~clk;

	// --- sequencer mirror: registers, phase flags, shared position, tx buffer ---
	logic [6:0]  tgt_addr      = '0;
	logic [8:0]  wr_len        = '0;
	logic [15:0] rd_len        = '0;
	logic        seq_busy      = 1'b0;
	logic        wr_exhausted  = 1'b1;
	logic        wr_phase_over = 1'b1;
	logic [15:0] pos           = '0;
	logic [7:0]  tx_buf [TX_DEPTH_DEF];
	bit          tx_loaded [TX_DEPTH_DEF];

	out_rec_t expected_recs[$];
	out_rec_t last_rec;
	out_rec_t due_rec;
	int       errors = 0;

	// idling rates in percent per beat / per cycle; 0 gives a clean stretch
	int in_gap_pct    = 0;
	int out_stall_pct = 0;

	// where a well-formed transaction stands: address byte owed, address ack owed
	bit addr_due     = 1'b0;
	bit addr_ack_due = 1'b0;

	// bytes left against a length; saturates once the position has run past it
	function automatic int unsigned left_of(int unsigned len);
		return (len > pos) ? len - pos : 0;
	endfunction

	function automatic ctl_t ack_setting(int unsigned rx_left);
		return (rx_left > 1) ? CTL_ENABLE : CTL_DISABLE;
	endfunction

	// every completion also turns the buffer interrupt off and drops busy
	function automatic void close_rec(inout out_rec_t r, input status_t st);
		r.done_res           = 1'b1;
		r.status             = st;
		r.buffer_irq_control = CTL_DISABLE;
		seq_busy             = 1'b0;
	endfunction

	// bus event while busy; priority start > (address, rx) > tx_empty
	function automatic void bus_step(input beat_t b, inout out_rec_t r);
		int unsigned tx_left;
		int unsigned rx_left;
		tx_left = wr_exhausted ? 0 : left_of(wr_len);
		rx_left = left_of(rd_len);
		if (b.start_sent) begin
			// read bit set once nothing is left to write
			r.send_valid = 1'b1;
			r.send_byte  = {tgt_addr, (tx_left == 0) ? 1'b1 : 1'b0};
			return;
		end
		if (b.address_done && tx_left == 0) begin
			r.ack_control        = ack_setting(rx_left);
			r.buffer_irq_control = CTL_ENABLE;
		end
		if (b.rx_not_empty && rx_left != 0) begin
			r.rx_valid = 1'b1;
			r.rx_index = pos;
			r.rx_byte  = b.byte_in;
			pos++;
			rx_left--;
			if (rx_left == 0) begin
				// last byte: stop, and the interrupt disable overrides any enable above
				r.gen_stop = 1'b1;
				close_rec(r, ST_OK);
			end else begin
				r.ack_control = ack_setting(rx_left);
			end
			return;
		end
		if (b.tx_empty && !wr_phase_over) begin
			if (wr_exhausted) begin
				// write phase over: repeated start, or stop when nothing to read
				pos          = '0;
				r.dummy_read = b.byte_finished;
				if (rd_len != 0) begin
					r.gen_start = 1'b1;
				end else begin
					r.gen_stop = 1'b1;
					close_rec(r, ST_OK);
				end
				wr_phase_over = 1'b1;
			end else begin
				r.buffer_irq_control = (tx_left <= 1) ? CTL_DISABLE : CTL_ENABLE;
				r.send_valid         = 1'b1;
				r.send_byte          = tx_buf[pos[7:0]];
				pos++;
				if (pos >= wr_len)
					wr_exhausted = 1'b1;
			end
		end
	endfunction

	// command record for one accepted beat; advances the mirror
	function automatic out_rec_t sequence_step(beat_t b);
		out_rec_t r;
		r = '0;
		case (b.kind)
			KIND_BEGIN: if (!seq_busy) begin
				seq_busy      = 1'b1;
				pos           = '0;
				wr_exhausted  = (wr_len == 0);
				wr_phase_over = (wr_len == 0);
				r.gen_start   = 1'b1;
			end
			KIND_LOAD: begin
				tx_buf[b.load_index]    = b.byte_in;
				tx_loaded[b.load_index] = 1'b1;
			end
			KIND_BUS: if (seq_busy) begin
				bus_step(b, r);
			end
			KIND_ERROR: if (seq_busy) begin
				if (b.ack_failure) begin
					r.gen_stop = 1'b1;
					close_rec(r, ST_NO_DEVICE);
				end else if (b.bus_fault) begin
					close_rec(r, ST_BUS_ERROR);
				end else begin
					close_rec(r, ST_UNEXPECTED);
				end
			end
			KIND_TIMEOUT: if (seq_busy) begin
				close_rec(r, ST_TIMEOUT);
			end
			default: ;
		endcase
		return r;
	endfunction

	// --- beat builders ---
	function automatic beat_t plain_beat(logic [2:0] k);
		beat_t b;
		b      = '0;
		b.kind = k;
		return b;
	endfunction

	function automatic beat_t load_beat(logic [7:0] idx, logic [7:0] d);
		beat_t b;
		b            = plain_beat(KIND_LOAD);
		b.load_index = idx;
		b.byte_in    = d;
		return b;
	endfunction

	function automatic beat_t bus_beat(bit st, bit ad, bit rx, bit te, bit bf, logic [7:0] d);
		beat_t b;
		b               = plain_beat(KIND_BUS);
		b.start_sent    = st;
		b.address_done  = ad;
		b.rx_not_empty  = rx;
		b.tx_empty      = te;
		b.byte_finished = bf;
		b.byte_in       = d;
		return b;
	endfunction

	function automatic beat_t err_beat(bit af, bit bf);
		beat_t b;
		b             = plain_beat(KIND_ERROR);
		b.ack_failure = af;
		b.bus_fault   = bf;
		return b;
	endfunction

	// --- input side ---
	// One beat through the handshake. Valid stays up from beat to beat and is
	// only dropped for a gap, so it never falls and rises in one time step.
	task automatic push_beat(beat_t b);
		if ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= b.kind;
		load_index    <= b.load_index;
		byte_in       <= b.byte_in;
		start_sent    <= b.start_sent;
		address_done  <= b.address_done;
		rx_not_empty  <= b.rx_not_empty;
		tx_empty      <= b.tx_empty;
		byte_finished <= b.byte_finished;
		ack_failure   <= b.ack_failure;
		bus_fault     <= b.bus_fault;
		do @(posedge clk); while (in_stall);
		last_rec = sequence_step(b);
		expected_recs.push_back(last_rec);
		// track the well-formed flow for the stimulus shaper
		if (last_rec.gen_start) begin
			addr_due     = 1'b1;
			addr_ack_due = 1'b0;
		end else if (b.kind == KIND_BUS && b.start_sent && last_rec.send_valid) begin
			addr_due     = 1'b0;
			addr_ack_due = 1'b1;
		end else if (b.kind == KIND_BUS && b.address_done) begin
			addr_ack_due = 1'b0;
		end
		if (last_rec.done_res) begin
			addr_due     = 1'b0;
			addr_ack_due = 1'b0;
		end
	endtask

	// A write-phase tx_empty would send tx_buf[pos]; make sure that entry has
	// been loaded first so no unwritten entry is ever read out.
	task automatic send_beat(beat_t b);
		if (b.kind == KIND_BUS && seq_busy && b.tx_empty && !wr_phase_over
				&& !wr_exhausted && !tx_loaded[pos[7:0]])
			push_beat(load_beat(pos[7:0], 8'($urandom_range(255))));
		push_beat(b);
	endtask

	// hold off the sender until every record is back, then let the pipe drain
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_recs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// all three registers back to back; only called once settled
	task automatic configure(logic [6:0] addr, logic [8:0] wlen, logic [15:0] rlen);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TARGET_ADDRESS;
		cfg_data  <= 16'(addr);
		@(posedge clk);
		cfg_index <= REG_WRITE_LENGTH;
		cfg_data  <= 16'(wlen);
		@(posedge clk);
		cfg_index <= REG_READ_LENGTH;
		cfg_data  <= rlen;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tgt_addr = addr;
		wr_len   = wlen;
		rd_len   = rlen;
	endtask

	// --- output side ---
	int stall_hold = 0;

	always @(posedge clk) begin
		if (stall_hold > 0)
			stall_hold--;
		else if ($urandom_range(99) < out_stall_pct)
			stall_hold = $urandom_range(13, 1);
		out_stall <= (stall_hold > 0);
	end

	task automatic match_field(string fld, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
		end
	endtask

	// each record beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_recs.size() == 0) begin
				errors++;
				$display("%0t: command record with none expected", $time);
			end else begin
				due_rec = expected_recs.pop_front();
				match_field("send_valid", due_rec.send_valid, send_valid);
				match_field("send_byte", due_rec.send_byte, send_byte);
				match_field("gen_start", due_rec.gen_start, gen_start);
				match_field("gen_stop", due_rec.gen_stop, gen_stop);
				match_field("ack_control", due_rec.ack_control, ack_control);
				match_field("buffer_irq_control", due_rec.buffer_irq_control,
					buffer_irq_control);
				match_field("dummy_read", due_rec.dummy_read, dummy_read);
				match_field("rx_valid", due_rec.rx_valid, rx_valid);
				match_field("rx_index", due_rec.rx_index, rx_index);
				match_field("rx_byte", due_rec.rx_byte, rx_byte);
				match_field("done_res", due_rec.done_res, done_res);
				match_field("status", due_rec.status, status);
			end
		end
	end

	// watchdog: too long without a beat on either channel
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// --- tests ---

	// full write-then-read transfer, top address, plus idle and busy begins
	task automatic test_write_then_read();
		in_gap_pct    = 25;
		out_stall_pct = 25;
		configure(7'h7F, 9'd2, 16'd2);
		send_beat(load_beat(8'd0, 8'h00));
		send_beat(load_beat(8'd1, 8'hFF));
		send_beat(bus_beat(1, 1, 1, 1, 1, 8'hFF));   // not busy: ignored
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(plain_beat(KIND_BEGIN));           // busy: ignored
		send_beat(bus_beat(1, 0, 0, 0, 0, 8'h00));   // address, write
		send_beat(bus_beat(0, 1, 0, 0, 0, 8'h00));   // ack'd, bytes still to write
		send_beat(bus_beat(0, 0, 0, 1, 0, 8'h00));   // first byte, irq kept on
		send_beat(bus_beat(0, 0, 0, 1, 1, 8'h00));   // last byte, irq off
		send_beat(bus_beat(0, 0, 0, 1, 1, 8'h00));   // repeated start + dummy read
		send_beat(bus_beat(1, 0, 0, 0, 0, 8'h00));   // address, read
		send_beat(bus_beat(0, 1, 0, 0, 0, 8'h00));   // ACK on, irq on
		send_beat(bus_beat(0, 0, 1, 0, 0, 8'hFF));   // ACK off before the last byte
		send_beat(bus_beat(0, 0, 1, 0, 0, 8'h00));   // stop, done ok
		settle();
	endtask

	// read only at address 0, every way a transfer can end, unknown kinds
	task automatic test_read_only_and_endings();
		int k;
		configure(7'h00, 9'd0, 16'd1);
		send_beat(plain_beat(KIND_TIMEOUT));         // not busy: ignored
		send_beat(err_beat(1'b1, 1'b1));             // not busy: ignored
		for (k = KIND_TIMEOUT + 1; k < 8; k++)
			send_beat(plain_beat(3'(k)));
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(bus_beat(1, 0, 0, 0, 0, 8'h00));   // read bit straight away
		// address ack and the only byte in one beat: irq disable wins
		send_beat(bus_beat(0, 1, 1, 0, 0, 8'h5A));
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(err_beat(1'b1, 1'b1));             // NACK beats bus fault
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(err_beat(1'b0, 1'b1));
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(err_beat(1'b0, 1'b0));             // neither flag: unexpected
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(plain_beat(KIND_TIMEOUT));
		settle();
	endtask

	// reads during the write phase push the position past write_length,
	// so the write count saturates at zero
	task automatic test_position_overrun();
		configure(7'h2A, 9'd2, 16'd5);
		send_beat(plain_beat(KIND_BEGIN));
		send_beat(bus_beat(0, 0, 1, 0, 0, 8'h11));
		send_beat(bus_beat(0, 0, 1, 0, 0, 8'h22));
		send_beat(bus_beat(0, 0, 1, 0, 0, 8'h33));
		send_beat(bus_beat(0, 0, 0, 1, 0, 8'h00));   // sends tx_buf[3], irq off
		send_beat(bus_beat(0, 0, 0, 1, 0, 8'h00));   // repeated start, no dummy
		send_beat(plain_beat(KIND_TIMEOUT));
		settle();
	endtask

	// mostly well-formed transfers with random content; the rest is noise
	function automatic beat_t shaped_beat();
		beat_t       b;
		logic [31:0] raw;
		int          roll;
		raw  = $urandom;
		roll = $urandom_range(99);
		if (roll < 12)
			b = beat_t'(raw[$bits(beat_t)-1:0]);
		else if (roll < 15)
			b = raw[31] ? plain_beat(KIND_TIMEOUT) : err_beat(raw[30], raw[29]);
		else if (!seq_busy)
			b = (raw[1:0] == 2'd0) ? load_beat(raw[15:8], raw[23:16]) : plain_beat(KIND_BEGIN);
		else if (addr_due)
			b = bus_beat(1, raw[0], raw[1], raw[2], raw[3], raw[15:8]);
		else if (addr_ack_due)
			b = bus_beat(0, 1, 0, raw[2], 0, raw[15:8]);
		else if (!wr_phase_over)
			b = bus_beat(0, 0, 0, 1, raw[3], raw[15:8]);
		else
			b = bus_beat(0, raw[1:0] == 2'd0, 1, 0, 0, raw[15:8]);
		return b;
	endfunction

	// phases of random traffic, each under fresh register settings;
	// short lengths mostly, with the extremes early on
	task automatic test_random_traffic(int phases, int per_phase, bit calm);
		int          p;
		int          n;
		logic [6:0]  addr;
		logic [8:0]  wlen;
		logic [15:0] rlen;
		for (p = 0; p < phases; p++) begin
			settle();
			addr = 7'($urandom_range(127));
			case ($urandom_range(9))
				0:       wlen = 9'd256;
				1:       wlen = 9'($urandom_range(256));
				default: wlen = 9'($urandom_range(4));
			endcase
			case ($urandom_range(9))
				0:       rlen = 16'hFFFF;
				1:       rlen = 16'($urandom_range(65535));
				default: rlen = 16'($urandom_range(4));
			endcase
			if (!calm && p == 0) begin
				addr = 7'h7F;
				wlen = 9'd256;
				rlen = 16'hFFFF;
			end else if (!calm && p == 1) begin
				addr = 7'h00;
				wlen = 9'd0;
				rlen = 16'd0;
			end
			configure(addr, wlen, rlen);
			case ($urandom_range(2))
				0:       in_gap_pct = 0;
				1:       in_gap_pct = 15;
				default: in_gap_pct = 40;
			endcase
			case ($urandom_range(2))
				0:       out_stall_pct = 0;
				1:       out_stall_pct = 10;
				default: out_stall_pct = 30;
			endcase
			if (calm) begin
				in_gap_pct    = 0;
				out_stall_pct = 0;
			end
			for (n = 0; n < per_phase; n++)
				send_beat(shaped_beat());
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_write_then_read();
		test_read_only_and_endings();
		test_position_overrun();
		test_random_traffic(9, 36, 1'b0);
		// closing stretch with no idling on either side
		test_random_traffic(1, 50, 1'b1);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
